// ===== hdl/rbst_pkg.sv =====
// shared types and constants for the ray box slab test
package rbst_pkg;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [15:0] dir_t;
  typedef logic signed [32:0] diff_t;

  localparam coord_t T_MAX = 32'sh7FFF_FFFF;
  localparam coord_t T_MIN = 32'sh8000_0000;

  localparam int QUO_BITS  = 32;
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = QUO_BITS / DIV_BITS;
  localparam int DIV_LAT   = DIV_STEPS + 2;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  typedef struct packed {
    logic [2:0] in_slab;
    logic [2:0] dzero;
  } side_t;

endpackage

// ===== hdl/rbst_ifs.sv =====
// request, result and register write channels
interface rbst_in_if import rbst_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t origin_x;
  coord_t origin_y;
  coord_t origin_z;
  dir_t   dir_x;
  dir_t   dir_y;
  dir_t   dir_z;
  modport source(output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 input ready);
  modport sink(input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               output ready);
endinterface

interface rbst_out_if import rbst_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   hit;
  coord_t t_near;
  coord_t t_far;
  modport source(output valid, hit, t_near, t_far, input ready);
  modport sink(input valid, hit, t_near, t_far, output ready);
endinterface

interface rbst_cfg_if import rbst_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] idx;
  logic [31:0]          data;
  modport source(output valid, idx, data, input ready);
  modport sink(input valid, idx, data, output ready);
endinterface

// ===== hdl/rbst_cfg.sv =====
// box bound registers
module rbst_cfg import rbst_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  rbst_cfg_if.sink cfg,
  output box_t    box
);

  box_t box_r;

  assign cfg.ready = 1'b1;
  assign box = box_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r.min_x <= T_MAX;
      box_r.min_y <= T_MAX;
      box_r.min_z <= T_MAX;
      box_r.max_x <= T_MIN;
      box_r.max_y <= T_MIN;
      box_r.max_z <= T_MIN;
    end else if (cfg.valid) begin
      unique case (cfg.idx)
        REG_BOX_MIN_X: box_r.min_x <= cfg.data;
        REG_BOX_MIN_Y: box_r.min_y <= cfg.data;
        REG_BOX_MIN_Z: box_r.min_z <= cfg.data;
        REG_BOX_MAX_X: box_r.max_x <= cfg.data;
        REG_BOX_MAX_Y: box_r.max_y <= cfg.data;
        REG_BOX_MAX_Z: box_r.max_z <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/rbst_div.sv =====
// pipelined saturating divide of a q17.16 difference by a q2.14 direction
module rbst_div import rbst_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  diff_t  diff,
  input  dir_t   dir,
  output coord_t quo
);

  logic [32:0] amag;
  logic [15:0] dmag;
  logic        ovf_a;
  logic [46:0] num_a;

  logic [15:0]         rem_r [0:DIV_STEPS];
  logic [QUO_BITS-1:0] q_r   [0:DIV_STEPS];
  logic [QUO_BITS-1:0] lo_r  [0:DIV_STEPS];
  logic [15:0]         d_r   [0:DIV_STEPS];
  logic                neg_r [0:DIV_STEPS];
  logic                ovf_r [0:DIV_STEPS];
  coord_t              quo_r;
  coord_t              quo_nxt;

  always_comb begin
    amag  = diff[32] ? 33'(-diff) : 33'(diff);
    dmag  = dir[15] ? 16'(-dir) : 16'(dir);
    ovf_a = {1'b0, amag} >= {dmag, 18'b0};
    num_a = {amag, 14'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {1'b0, num_a[46:32]};
      q_r[0]   <= '0;
      lo_r[0]  <= num_a[31:0];
      d_r[0]   <= dmag;
      neg_r[0] <= diff[32] ^ dir[15];
      ovf_r[0] <= ovf_a;
    end
  end

  for (genvar g = 1; g <= DIV_STEPS; g++) begin : g_step
    logic [15:0]         r_c;
    logic [QUO_BITS-1:0] q_c;
    logic [QUO_BITS-1:0] lo_c;
    logic [16:0]         t_c;

    always_comb begin
      r_c  = rem_r[g-1];
      q_c  = q_r[g-1];
      lo_c = lo_r[g-1];
      t_c  = '0;
      for (int j = 0; j < DIV_BITS; j++) begin
        t_c  = {r_c, lo_c[QUO_BITS-1]};
        lo_c = {lo_c[QUO_BITS-2:0], 1'b0};
        if (t_c >= {1'b0, d_r[g-1]}) begin
          r_c = 16'(t_c - {1'b0, d_r[g-1]});
          q_c = {q_c[QUO_BITS-2:0], 1'b1};
        end else begin
          r_c = t_c[15:0];
          q_c = {q_c[QUO_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= r_c;
        q_r[g]   <= q_c;
        lo_r[g]  <= lo_c;
        d_r[g]   <= d_r[g-1];
        neg_r[g] <= neg_r[g-1];
        ovf_r[g] <= ovf_r[g-1];
      end
    end
  end

  always_comb begin
    if (ovf_r[DIV_STEPS]) begin
      quo_nxt = neg_r[DIV_STEPS] ? T_MIN : T_MAX;
    end else if (neg_r[DIV_STEPS]) begin
      quo_nxt = (q_r[DIV_STEPS] > 32'h8000_0000) ? T_MIN : 32'(-q_r[DIV_STEPS]);
    end else begin
      quo_nxt = q_r[DIV_STEPS][31] ? T_MAX : q_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) quo_r <= quo_nxt;
  end

  assign quo = quo_r;

endmodule

// ===== hdl/ray_box_slab_test_top.sv =====
// ray against axis-aligned box slab test, top level
// throughput: one request per cycle while the output is not stalled, set by the six pipelined dividers
// dividers resolve 4 quotient bits per stage over 8 stages
// stalls freeze the whole pipeline; nothing is dropped or repeated
// reset (rst_n low, synchronous) clears valids and loads the empty box
module ray_box_slab_test_top import rbst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rbst_in_if.sink   in_req,
  rbst_out_if.source out_res,
  rbst_cfg_if.sink  cfg_wr
);

  box_t   box;
  logic   en;

  logic   v1_r;
  diff_t  dlo_r [3];
  diff_t  dhi_r [3];
  dir_t   dir_r [3];
  side_t  s1_r;

  coord_t qlo [3];
  coord_t qhi [3];

  logic   vd_r   [DIV_LAT];
  side_t  side_r [DIV_LAT];

  logic   v12_r;
  coord_t ent_r [3];
  coord_t lev_r [3];
  coord_t ent_nxt [3];
  coord_t lev_nxt [3];

  logic   v13_r;
  coord_t tn_r, tf_r, tn_nxt, tf_nxt;

  logic   ov_r;
  logic   hit_r;
  coord_t otn_r, otf_r;

  coord_t org [3];
  dir_t   dir [3];
  coord_t bmin [3];
  coord_t bmax [3];

  rbst_cfg u_cfg (.clk(clk), .rst_n(rst_n), .cfg(cfg_wr), .box(box));

  assign en = !ov_r || out_res.ready;
  assign in_req.ready = en;

  assign org  = '{in_req.origin_x, in_req.origin_y, in_req.origin_z};
  assign dir  = '{in_req.dir_x, in_req.dir_y, in_req.dir_z};
  assign bmin = '{box.min_x, box.min_y, box.min_z};
  assign bmax = '{box.max_x, box.max_y, box.max_z};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        dlo_r[a] <= {bmin[a][31], bmin[a]} - {org[a][31], org[a]};
        dhi_r[a] <= {bmax[a][31], bmax[a]} - {org[a][31], org[a]};
        dir_r[a] <= dir[a];
        s1_r.in_slab[a] <= (org[a] >= bmin[a]) && (org[a] <= bmax[a]);
        s1_r.dzero[a]   <= dir[a] == '0;
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbst_div u_dlo (.clk(clk), .en(en), .diff(dlo_r[a]), .dir(dir_r[a]), .quo(qlo[a]));
    rbst_div u_dhi (.clk(clk), .en(en), .diff(dhi_r[a]), .dir(dir_r[a]), .quo(qhi[a]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= s1_r;
      for (int k = 1; k < DIV_LAT; k++) side_r[k] <= side_r[k-1];
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (side_r[DIV_LAT-1].dzero[a]) begin
        ent_nxt[a] = side_r[DIV_LAT-1].in_slab[a] ? T_MIN : T_MAX;
        lev_nxt[a] = side_r[DIV_LAT-1].in_slab[a] ? T_MAX : T_MIN;
      end else if (qlo[a] < qhi[a]) begin
        ent_nxt[a] = qlo[a];
        lev_nxt[a] = qhi[a];
      end else begin
        ent_nxt[a] = qhi[a];
        lev_nxt[a] = qlo[a];
      end
    end
    tn_nxt = ent_r[0];
    if (ent_r[1] > tn_nxt) tn_nxt = ent_r[1];
    if (ent_r[2] > tn_nxt) tn_nxt = ent_r[2];
    tf_nxt = lev_r[0];
    if (lev_r[1] < tf_nxt) tf_nxt = lev_r[1];
    if (lev_r[2] < tf_nxt) tf_nxt = lev_r[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ent_r <= ent_nxt;
      lev_r <= lev_nxt;
      tn_r  <= tn_nxt;
      tf_r  <= tf_nxt;
      hit_r <= !(tf_r < 0) && !(tn_r > tf_r);
      otn_r <= tn_r;
      otf_r <= tf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) vd_r[k] <= 1'b0;
      v12_r <= 1'b0;
      v13_r <= 1'b0;
      ov_r  <= 1'b0;
    end else if (en) begin
      v1_r    <= in_req.valid;
      vd_r[0] <= v1_r;
      for (int k = 1; k < DIV_LAT; k++) vd_r[k] <= vd_r[k-1];
      v12_r   <= vd_r[DIV_LAT-1];
      v13_r   <= v12_r;
      ov_r    <= v13_r;
    end
  end

  assign out_res.valid  = ov_r;
  assign out_res.hit    = hit_r;
  assign out_res.t_near = otn_r;
  assign out_res.t_far  = otf_r;

endmodule

// ===== hdl/rbst_chk.sv =====
// port level checks for the slab test top
module rbst_chk import rbst_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input logic   out_hit,
  input coord_t out_t_near,
  input coord_t out_t_far
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hit) && $stable(out_t_near) && $stable(out_t_far))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("request refused without output stall");

  a_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> (out_t_near <= out_t_far) && !out_t_far[31])
    else $error("hit with empty interval");

endmodule

bind ray_box_slab_test_top rbst_chk u_rbst_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_req.ready),
  .out_valid(out_res.valid),
  .out_ready(out_res.ready),
  .out_hit(out_res.hit),
  .out_t_near(out_res.t_near),
  .out_t_far(out_res.t_far)
);

// ===== dv/tb_top.sv =====
// testbench for the ray box slab test: random and directed rays checked against a predictor
`timescale 1ns / 1ps
module tb_top;
  import rbst_pkg::*;

  typedef struct {
    logic   hit;
    coord_t t_near;
    coord_t t_far;
  } slab_res_t;

  class slab_board;
    slab_res_t pending[$];
    longint box_lo[3];
    longint box_hi[3];
    int errors;
    int checked;

    function void set_reg(cfg_reg_t r, logic [31:0] v);
      case (r)
        REG_BOX_MIN_X: box_lo[0] = $signed(v);
        REG_BOX_MIN_Y: box_lo[1] = $signed(v);
        REG_BOX_MIN_Z: box_lo[2] = $signed(v);
        REG_BOX_MAX_X: box_hi[0] = $signed(v);
        REG_BOX_MAX_Y: box_hi[1] = $signed(v);
        REG_BOX_MAX_Z: box_hi[2] = $signed(v);
        default: ;
      endcase
    endfunction

    function longint clamp_t(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void note_ray(coord_t o[3], dir_t d[3]);
      longint tn, tf, a, b, en, lv;
      slab_res_t r;
      tn = -64'sd2147483648;
      tf = 64'sd2147483647;
      for (int i = 0; i < 3; i++) begin
        if (d[i] == 0) begin
          if (o[i] >= box_lo[i] && o[i] <= box_hi[i]) begin
            en = -64'sd2147483648; lv = 64'sd2147483647;
          end else begin
            en = 64'sd2147483647; lv = -64'sd2147483648;
          end
        end else begin
          a = clamp_t(((box_lo[i] - longint'(o[i])) * 16384) / longint'(d[i]));
          b = clamp_t(((box_hi[i] - longint'(o[i])) * 16384) / longint'(d[i]));
          en = a < b ? a : b;
          lv = a < b ? b : a;
        end
        if (en > tn) tn = en;
        if (lv < tf) tf = lv;
      end
      r.hit = !(tf < 0 || tn > tf);
      r.t_near = tn[31:0];
      r.t_far = tf[31:0];
      pending.push_back(r);
    endfunction

    task check_result(logic hit, coord_t tn, coord_t tf);
      slab_res_t e;
      checked++;
      if (pending.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit) report($sformatf("hit %b want %b", hit, e.hit));
      if (tn !== e.t_near) report($sformatf("t_near %h want %h", tn, e.t_near));
      if (tf !== e.t_far) report($sformatf("t_far %h want %h", tf, e.t_far));
    endtask

    task report(string s);
      errors++;
      $display("mismatch #%0d: %s", errors, s);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  rbst_in_if in_req();
  rbst_out_if out_res();
  rbst_cfg_if cfg_wr();
  slab_board sb;
  int send_idle, recv_stall, hits;

  ray_box_slab_test_top dut (.clk, .rst_n, .in_req, .out_res, .cfg_wr);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    in_req.valid = 0;
    in_req.origin_x = 0; in_req.origin_y = 0; in_req.origin_z = 0;
    in_req.dir_x = 0; in_req.dir_y = 0; in_req.dir_z = 0;
    out_res.ready = 0;
    cfg_wr.valid = 0; cfg_wr.idx = 0; cfg_wr.data = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_res.valid && out_res.ready) begin
      sb.check_result(out_res.hit, out_res.t_near, out_res.t_far);
      if (out_res.hit) hits++;
    end
    out_res.ready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic write_reg(cfg_reg_t r, logic [31:0] v);
    cfg_wr.valid <= 1;
    cfg_wr.idx <= r;
    cfg_wr.data <= v;
    do @(posedge clk); while (!cfg_wr.ready);
    sb.set_reg(r, v);
  endtask

  task automatic send_ray(coord_t ox, coord_t oy, coord_t oz, dir_t dx, dir_t dy, dir_t dz);
    coord_t o[3];
    dir_t d[3];
    while ($urandom_range(99) < send_idle) begin
      in_req.valid <= 0;
      @(posedge clk);
    end
    in_req.valid <= 1;
    in_req.origin_x <= ox; in_req.origin_y <= oy; in_req.origin_z <= oz;
    in_req.dir_x <= dx; in_req.dir_y <= dy; in_req.dir_z <= dz;
    do @(posedge clk); while (!in_req.ready);
    o[0] = ox; o[1] = oy; o[2] = oz;
    d[0] = dx; d[1] = dy; d[2] = dz;
    sb.note_ray(o, d);
  endtask

  task automatic drain;
    in_req.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DIV_LAT + 8) @(posedge clk);
  endtask

  task automatic load_box(coord_t lx, coord_t ly, coord_t lz, coord_t hx, coord_t hy, coord_t hz);
    write_reg(REG_BOX_MIN_X, lx); write_reg(REG_BOX_MIN_Y, ly);
    write_reg(REG_BOX_MIN_Z, lz); write_reg(REG_BOX_MAX_X, hx);
    write_reg(REG_BOX_MAX_Y, hy); write_reg(REG_BOX_MAX_Z, hz);
    cfg_wr.valid <= 0;
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
      default: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
    endcase
  endfunction

  function automatic dir_t rand_dir();
    case ($urandom_range(9))
      0: return 0;
      1: return 16'sh8000;
      2: return 16'sh7fff;
      3: return $signed(16'($urandom_range(0, 6))) - 3;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int n, int idle, int stall, int mode);
    send_idle = idle;
    recv_stall = stall;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        send_ray(rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_dir(), 0, 0);
      else
        send_ray(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                 rand_dir(), rand_dir(), rand_dir());
      if (i == n / 2 && mode == 1) drain();
    end
    drain();
  endtask

  initial begin
    sb = new();
    sb.set_reg(REG_BOX_MIN_X, T_MAX); sb.set_reg(REG_BOX_MIN_Y, T_MAX);
    sb.set_reg(REG_BOX_MIN_Z, T_MAX); sb.set_reg(REG_BOX_MAX_X, T_MIN);
    sb.set_reg(REG_BOX_MAX_Y, T_MIN); sb.set_reg(REG_BOX_MAX_Z, T_MIN);
    send_idle = 0;
    recv_stall = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset box: inverted bounds
    send_ray(0, 0, 0, 16'sh4000, 16'sh4000, 16'sh4000);
    send_ray(0, 0, 0, 0, 16'sh4000, 16'sh4000);
    send_ray(T_MAX, T_MIN, 0, 16'sh7fff, 16'sh8000, 1);
    drain();

    load_box(-(1 << 16), -(1 << 16), -(1 << 16), 1 << 16, 1 << 16, 1 << 16);
    send_ray(-(5 << 16), 0, 0, 16'sh4000, 0, 0);
    send_ray(-(5 << 16), 0, 0, 16'shc000, 0, 0);
    send_ray(0, 0, 0, 16'sh4000, 16'sh2000, 16'shf000);
    send_ray(1 << 16, 1 << 16, 1 << 16, 0, 0, 0);
    send_ray((1 << 16) + 1, 0, 0, 0, 16'sh4000, 16'sh4000);
    send_ray(-(1 << 16), 0, 0, 0, 0, 0);
    send_ray(T_MIN, T_MIN, T_MIN, 1, 1, 1);
    send_ray(T_MAX, T_MAX, T_MAX, 16'sh8000, 16'sh8000, 16'sh8000);
    send_ray(0, 5 << 16, 0, 16'sh4000, 16'sh4000, 0);
    send_ray(-(3 << 16), -(3 << 16), 0, 16'sh4000, 16'sh4000, 0);
    drain();

    load_box(T_MIN, T_MIN, T_MIN, T_MAX, T_MAX, T_MAX);
    send_ray(T_MIN, T_MAX, 0, 1, 16'shffff, 16'sh7fff);
    send_ray(0, 0, 0, 0, 0, 0);
    send_ray(T_MAX, 0, T_MIN, 16'sh8000, 0, 16'sh0001);
    drain();

    load_box(T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX);
    send_ray(0, 0, 0, 1, 1, 1);
    send_ray(T_MAX, T_MAX, T_MAX, 0, 0, 0);
    drain();

    load_box(-(4 << 16), -(4 << 16), -(4 << 16), 4 << 16, 4 << 16, 4 << 16);
    random_phase(400, 0, 0, 1);
    random_phase(250, 84, 0, 1);
    random_phase(250, 0, 84, 1);
    random_phase(250, 31, 31, 1);
    load_box(-(2 << 16), 1 << 16, -(9 << 16), 3 << 16, 1 << 16, -(5 << 16));
    random_phase(300, 31, 31, 1);
    load_box(-70000, -100, -50, 70000, 100, 60);
    random_phase(200, 0, 0, 2);
    load_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    random_phase(250, 31, 31, 0);

    $display("covered %0d rays, %0d hits, over several boxes and idle mixes",
             sb.checked, hits);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
